FILE: rtl/indexed_stack_list_engine_assert.svh
// Assertion macros used by the checker file of the stack list engine.
`ifndef INDEXED_STACK_LIST_ENGINE_ASSERT_SVH
`define INDEXED_STACK_LIST_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ISLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isle assertion failed");

`endif

FILE: rtl/isle_pkg.sv
`timescale 1ns / 1ps

package isle_pkg;

  localparam int unsigned DefDepth = 128;
  localparam int unsigned DataW    = 32;
  localparam int unsigned FuncW    = 3;
  localparam int unsigned IndexW   = 7;
  localparam int unsigned FillW    = 8;
  localparam int unsigned StatusW  = 3;

  typedef enum logic [FuncW-1:0] {
    FUNC_PUSH     = 3'd0,
    FUNC_POP_TOP  = 3'd1,
    FUNC_POP_AT   = 3'd2,
    FUNC_REMOVE   = 3'd3,
    FUNC_INSERT   = 3'd4,
    FUNC_CHANGE   = 3'd5,
    FUNC_PEEK     = 3'd6,
    FUNC_COUNT    = 3'd7
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // Action that a wave performs as it passes through the cells.
  typedef enum logic [2:0] {
    WAVE_NONE       = 3'd0,
    WAVE_INSERT     = 3'd1,
    WAVE_REMOVE_AT  = 3'd2,
    WAVE_REMOVE_VAL = 3'd3,
    WAVE_WRITE      = 3'd4,
    WAVE_READ       = 3'd5
  } wave_e;

  typedef struct packed {
    logic [FuncW-1:0]         func;
    logic [IndexW-1:0]        index;
    logic signed [DataW-1:0]  value;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0]  read_value;
    logic [FillW-1:0]         fill_count;
    logic [StatusW-1:0]       status;
  } out_t;

  // Token that travels up the cell row, one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [DataW-1:0]  carry;
  } tok_t;

  // Command held steady in every cell while a wave runs.
  typedef struct packed {
    wave_e             op;
    logic [DataW-1:0]  value;
  } cmd_t;

endpackage

FILE: rtl/isle_cell.sv
`timescale 1ns / 1ps

// One stack entry. It acts when the token passes and hands the token on.
module isle_cell #(
  parameter int unsigned DEPTH = isle_pkg::DefDepth,
  parameter int unsigned IDX   = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  isle_pkg::cmd_t             cmd_i,
  input  logic [$clog2(DEPTH)-1:0]   idx_i,
  input  logic [$clog2(DEPTH+1)-1:0] fill_i,
  input  logic [isle_pkg::DataW-1:0] up_entry_i,
  input  isle_pkg::tok_t             tok_i,
  output isle_pkg::tok_t             tok_o,
  output logic [isle_pkg::DataW-1:0] entry_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [isle_pkg::DataW-1:0] entry_q, entry_d, shift_val;
  isle_pkg::tok_t             tok_q, tok_d;
  logic                       at_idx, used, above_used, within_fill, match;

  assign at_idx      = (idx_i == IW'(IDX));
  assign used        = (CW'(IDX) < fill_i);
  assign above_used  = (CW'(IDX + 1) < fill_i);
  assign within_fill = (CW'(IDX) <= fill_i);
  assign shift_val   = above_used ? up_entry_i : '0;
  assign match       = used && !tok_i.hit && (entry_q == cmd_i.value);

  always_comb begin
    entry_d = entry_q;
    tok_d   = tok_i;
    if (tok_i.valid) begin
      unique case (cmd_i.op)
        isle_pkg::WAVE_INSERT: begin
          if (at_idx) begin
            entry_d     = cmd_i.value;
            tok_d.carry = entry_q;
            tok_d.hit   = 1'b1;
          end else if (tok_i.hit && within_fill) begin
            entry_d     = tok_i.carry;
            tok_d.carry = entry_q;
          end
        end
        isle_pkg::WAVE_REMOVE_AT: begin
          if (at_idx) begin
            tok_d.carry = entry_q;
            tok_d.hit   = 1'b1;
          end
          if ((at_idx || tok_i.hit) && used) begin
            entry_d = shift_val;
          end
        end
        isle_pkg::WAVE_REMOVE_VAL: begin
          if (match) begin
            tok_d.hit = 1'b1;
          end
          if ((match || tok_i.hit) && used) begin
            entry_d = shift_val;
          end
        end
        isle_pkg::WAVE_WRITE: begin
          if (at_idx) begin
            entry_d = cmd_i.value;
          end
        end
        isle_pkg::WAVE_READ: begin
          if (at_idx) begin
            tok_d.carry = entry_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      tok_q   <= '0;
    end else begin
      entry_q <= entry_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o   = tok_q;
  assign entry_o = entry_q;

endmodule

FILE: rtl/isle_ctrl.sv
`timescale 1ns / 1ps

// Checks each item, launches a wave into the cell row when the item needs one, and builds the result.
module isle_ctrl #(
  parameter int unsigned DEPTH = isle_pkg::DefDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  isle_pkg::in_t              in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output isle_pkg::out_t             out_o,
  output isle_pkg::cmd_t             cmd_o,
  output logic [$clog2(DEPTH)-1:0]   idx_o,
  output logic [$clog2(DEPTH+1)-1:0] fill_o,
  output isle_pkg::tok_t             tok_o,
  input  isle_pkg::tok_t             tok_i
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);
  localparam int unsigned XW = (CW > isle_pkg::IndexW) ? CW : isle_pkg::IndexW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     fill_q, fill_d;
  isle_pkg::cmd_t    cmd_q, cmd_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic              launch_q, launch_d;
  isle_pkg::out_t    out_q, out_d;

  isle_pkg::func_e   func;
  isle_pkg::status_e chk_status;
  isle_pkg::wave_e   chk_op;
  logic [IW-1:0]     chk_idx;
  logic              full, empty, idx_lt, idx_le;

  assign func   = isle_pkg::func_e'(in_i.func);
  assign full   = (fill_q == CW'(DEPTH));
  assign empty  = (fill_q == '0);
  assign idx_lt = (XW'(in_i.index) < XW'(fill_q));
  assign idx_le = (XW'(in_i.index) <= XW'(fill_q));

  // Decide from the function, the index and the fill alone whether the item fails or which wave it needs.
  always_comb begin
    chk_status = isle_pkg::ST_OK;
    chk_op     = isle_pkg::WAVE_NONE;
    chk_idx    = IW'(in_i.index);
    unique case (func)
      isle_pkg::FUNC_PUSH: begin
        chk_idx = IW'(fill_q);
        if (full) chk_status = isle_pkg::ST_OVERFLOW;
        else chk_op = isle_pkg::WAVE_INSERT;
      end
      isle_pkg::FUNC_POP_TOP: begin
        chk_idx = IW'(fill_q - CW'(1));
        if (empty) chk_status = isle_pkg::ST_UNDERFLOW;
        else chk_op = isle_pkg::WAVE_REMOVE_AT;
      end
      isle_pkg::FUNC_POP_AT: begin
        if (empty) chk_status = isle_pkg::ST_UNDERFLOW;
        else if (!idx_lt) chk_status = isle_pkg::ST_BAD_INDEX;
        else chk_op = isle_pkg::WAVE_REMOVE_AT;
      end
      isle_pkg::FUNC_REMOVE: begin
        if (empty) chk_status = isle_pkg::ST_NOT_FOUND;
        else chk_op = isle_pkg::WAVE_REMOVE_VAL;
      end
      isle_pkg::FUNC_INSERT: begin
        if (full) chk_status = isle_pkg::ST_OVERFLOW;
        else if (!idx_le) chk_status = isle_pkg::ST_BAD_INDEX;
        else chk_op = isle_pkg::WAVE_INSERT;
      end
      isle_pkg::FUNC_CHANGE: begin
        if (!idx_lt) chk_status = isle_pkg::ST_BAD_INDEX;
        else chk_op = isle_pkg::WAVE_WRITE;
      end
      isle_pkg::FUNC_PEEK: begin
        if (empty) chk_status = isle_pkg::ST_UNDERFLOW;
        else if (!idx_lt) chk_status = isle_pkg::ST_BAD_INDEX;
        else chk_op = isle_pkg::WAVE_READ;
      end
      isle_pkg::FUNC_COUNT: begin
        if (empty) chk_status = isle_pkg::ST_UNDERFLOW;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    launch_d = 1'b0;
    out_d    = out_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (chk_op == isle_pkg::WAVE_NONE) begin
            out_d.read_value = '0;
            out_d.fill_count = isle_pkg::FillW'(fill_q);
            out_d.status     = chk_status;
            state_d          = S_DONE;
          end else begin
            cmd_d.op    = chk_op;
            cmd_d.value = in_i.value;
            idx_d       = chk_idx;
            launch_d    = 1'b1;
            state_d     = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (tok_i.valid) begin
          out_d.read_value = '0;
          out_d.status     = isle_pkg::ST_OK;
          unique case (cmd_q.op)
            isle_pkg::WAVE_INSERT: fill_d = fill_q + CW'(1);
            isle_pkg::WAVE_REMOVE_AT: begin
              fill_d           = fill_q - CW'(1);
              out_d.read_value = tok_i.carry;
            end
            isle_pkg::WAVE_REMOVE_VAL: begin
              if (tok_i.hit) fill_d = fill_q - CW'(1);
              else out_d.status = isle_pkg::ST_NOT_FOUND;
            end
            isle_pkg::WAVE_READ: out_d.read_value = tok_i.carry;
            default: begin
            end
          endcase
          out_d.fill_count = isle_pkg::FillW'(fill_d);
          state_d          = S_DONE;
        end
      end
      S_DONE: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      launch_q <= 1'b0;
      cmd_q    <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      launch_q <= launch_d;
      cmd_q    <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    out_q <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign out_o       = out_q;
  assign cmd_o       = cmd_q;
  assign idx_o       = idx_q;
  assign fill_o      = fill_q;
  assign tok_o       = '{valid: launch_q, hit: 1'b0, carry: '0};

endmodule

FILE: rtl/indexed_stack_list_engine.sv
`timescale 1ns / 1ps

// Indexed stack list engine: a bounded stack of DEPTH signed 32-bit entries
// that also supports list operations (pop at an index, remove the first
// matching value, insert at an index, change, peek and count). Each entry
// lives in its own cell of a row; entry 0 is the bottom. An operation that
// touches the entries runs as a token wave that enters the bottom cell in the
// cycle after the item is accepted and climbs one cell per cycle; its result
// is registered when the token returns from the top cell. An operation that fails
// its checks, a count, or a remove on an empty stack skips the wave and
// answers in the cycle after acceptance. The block takes one item at a time:
// the next item is accepted in the cycle after the result is taken. Errors
// (overflow, underflow, index beyond the fill, value not found) leave the
// stack unchanged and return a zero read value.
module indexed_stack_list_engine #(
  parameter int unsigned DEPTH = isle_pkg::DefDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  isle_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output isle_pkg::out_t out_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  isle_pkg::cmd_t             cmd;
  logic [IW-1:0]              idx;
  logic [CW-1:0]              fill;
  // Token links: link i feeds cell i, link DEPTH returns to the controller.
  isle_pkg::tok_t             tok_w   [DEPTH+1];
  // Entry of cell i as seen by cell i-1; the slot above the top reads zero.
  logic [isle_pkg::DataW-1:0] entry_w [1:DEPTH];

  isle_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o),
    .cmd_o      (cmd),
    .idx_o      (idx),
    .fill_o     (fill),
    .tok_o      (tok_w[0]),
    .tok_i      (tok_w[DEPTH])
  );

  assign entry_w[DEPTH] = '0;

  // The cell row. Each cell reads only its upper neighbor's entry, which the
  // wave has not yet reached, so a removal shifts entries down in wave order.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_bottom
      isle_cell #(
        .DEPTH(DEPTH),
        .IDX  (i)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .cmd_i     (cmd),
        .idx_i     (idx),
        .fill_i    (fill),
        .up_entry_i(entry_w[i+1]),
        .tok_i     (tok_w[i]),
        .tok_o     (tok_w[i+1]),
        .entry_o   ()
      );
    end else begin : g_upper
      isle_cell #(
        .DEPTH(DEPTH),
        .IDX  (i)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .cmd_i     (cmd),
        .idx_i     (idx),
        .fill_i    (fill),
        .up_entry_i(entry_w[i+1]),
        .tok_i     (tok_w[i]),
        .tok_o     (tok_w[i+1]),
        .entry_o   (entry_w[i])
      );
    end
  end

endmodule

FILE: rtl/isle_checker.sv
`timescale 1ns / 1ps
`include "indexed_stack_list_engine_assert.svh"

// Port-level checks of the stack list engine.
module isle_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input isle_pkg::in_t  in_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input isle_pkg::out_t out_o
);

  logic in_acc;
  logic out_stall;
  logic underflow_res;
  logic nonzero_read;

  assign in_acc        = in_valid_i && in_ready_o && (in_i.func == in_i.func);
  assign out_stall     = out_valid_o && !out_ready_i;
  assign underflow_res = out_valid_o && (out_o.status == isle_pkg::ST_UNDERFLOW);
  assign nonzero_read  = out_valid_o && (out_o.read_value != '0);

  `ISLE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_o))
  `ISLE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !in_ready_o)
  `ISLE_ASSERT_NOW(a_one_item, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `ISLE_ASSERT_NOW(a_underflow_empty, clk_i, rst_ni, underflow_res, out_o.fill_count == '0)
  `ISLE_ASSERT_NOW(a_read_only_ok, clk_i, rst_ni, nonzero_read, out_o.status == isle_pkg::ST_OK)

endmodule

bind indexed_stack_list_engine isle_checker u_isle_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_i       (in_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_o      (out_o)
);
